// ===== hdl/cap_pkg.sv =====
package cap_pkg;

   localparam int NUM_AXES   = 3;
   localparam int ANGLE_W    = 16;
   localparam int GAIN_W     = 16;
   localparam int GAINS_W    = 3 * GAIN_W;
   localparam int LIMITS_W   = 4 * ANGLE_W;
   localparam int DT_W       = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = LIMITS_W;

   // datapath widths
   localparam int ERR_W      = ANGLE_W + 2;
   localparam int FRAC_W     = 16;
   localparam int INTEG_W    = 32;
   localparam int ACC_W      = INTEG_W + 4;
   localparam int MUL_A_W    = INTEG_W + 1;
   localparam int MUL_B_W    = GAIN_W + 1;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;
   localparam int CMD_SHIFT  = 24;
   localparam int DIFF_SHIFT = 8;
   localparam int SUM_W      = 52;
   localparam int DIFF_W     = SUM_W - DIFF_SHIFT;
   localparam int DIFF_LO_W  = DIFF_W / 2;
   localparam int DRV_W      = 62;
   localparam int QUO_W      = DRV_W - CMD_SHIFT;

   localparam int HALF_TURN  = 180;
   localparam int FULL_TURN  = 360;

   typedef logic signed [ANGLE_W-1:0] angle_type;

   typedef logic [1:0] axis_type;
   localparam axis_type AXIS_ROLL  = 2'd0;
   localparam axis_type AXIS_PITCH = 2'd1;
   localparam axis_type AXIS_YAW   = 2'd2;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;
   localparam csr_index_type CSR_GAINS_ROLL   = 3'd0;
   localparam csr_index_type CSR_GAINS_PITCH  = 3'd1;
   localparam csr_index_type CSR_GAINS_YAW    = 3'd2;
   localparam csr_index_type CSR_LIMITS_ROLL  = 3'd3;
   localparam csr_index_type CSR_LIMITS_PITCH = 3'd4;
   localparam csr_index_type CSR_LIMITS_YAW   = 3'd5;
   localparam csr_index_type CSR_TIME_STEP    = 3'd6;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ERR,
      ST_MDT,
      ST_INTEG,
      ST_CMD1,
      ST_CMD2,
      ST_RLO,
      ST_RHI,
      ST_OUT,
      ST_EMIT
   } cap_state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_ERR,
      OP_MDT,
      OP_INTEG,
      OP_CMD1,
      OP_CMD2,
      OP_RLO,
      OP_RHI,
      OP_OUT,
      OP_EMIT
   } cap_op_type;

   typedef struct packed {
      cap_op_type op;
      axis_type   axis;
   } cap_cmd_type;

endpackage

// ===== hdl/cap_if.sv =====
interface cap_req_if import cap_pkg::*; ();
   logic      valid;
   logic      ready;
   angle_type desired_roll;
   angle_type desired_pitch;
   angle_type desired_yaw;
   angle_type sensed_roll;
   angle_type sensed_pitch;
   angle_type sensed_yaw;
   angle_type corrected_roll;
   angle_type corrected_pitch;
   angle_type corrected_yaw;

   modport source (
      output valid, desired_roll, desired_pitch, desired_yaw,
             sensed_roll, sensed_pitch, sensed_yaw,
             corrected_roll, corrected_pitch, corrected_yaw,
      input  ready
   );
   modport sink (
      input  valid, desired_roll, desired_pitch, desired_yaw,
             sensed_roll, sensed_pitch, sensed_yaw,
             corrected_roll, corrected_pitch, corrected_yaw,
      output ready
   );
endinterface

interface cap_rsp_if import cap_pkg::*; ();
   logic      valid;
   logic      ready;
   angle_type roll_drive;
   angle_type pitch_drive;
   angle_type yaw_drive;

   modport source (output valid, roll_drive, pitch_drive, yaw_drive, input ready);
   modport sink   (input valid, roll_drive, pitch_drive, yaw_drive, output ready);
endinterface

// ===== hdl/cascaded_attitude_pi_controller.sv =====
// Three-axis cascaded PI attitude controller. Each req beat carries desired,
// sensed and drift-corrected roll/pitch/yaw angles; each one yields exactly one
// rsp beat with the clamped roll/pitch/yaw drives, and the per-axis integrators
// advance by error*dt every beat. The axes are computed one after another on a
// single shared 33x17 multiplier, each in the steps err, mdt, integ, cmd1,
// cmd2, rlo, rhi and out; a beat is loaded while idle, its three axes are
// computed, and it is handed off to the output register, and only then does
// req_ready return. The result sits in an output register, so the next beat is
// accepted while it waits to be taken; the hand-off of that next beat stalls
// until the previous result has been taken. Gains, limits and dt are written
// through the csr port; the user must do so while idle, unenforced by the block.
module cascaded_attitude_pi_controller import cap_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   cap_req_if.sink               req_bus,
   cap_rsp_if.source             rsp_bus,
   input  logic                  csr_wr_en,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cap_cmd_type cmd;
   angle_type   des [NUM_AXES];
   angle_type   sen [NUM_AXES];
   angle_type   cor [NUM_AXES];
   angle_type   drive [NUM_AXES];

   assign des[AXIS_ROLL]  = req_bus.desired_roll;
   assign des[AXIS_PITCH] = req_bus.desired_pitch;
   assign des[AXIS_YAW]   = req_bus.desired_yaw;
   assign sen[AXIS_ROLL]  = req_bus.sensed_roll;
   assign sen[AXIS_PITCH] = req_bus.sensed_pitch;
   assign sen[AXIS_YAW]   = req_bus.sensed_yaw;
   assign cor[AXIS_ROLL]  = req_bus.corrected_roll;
   assign cor[AXIS_PITCH] = req_bus.corrected_pitch;
   assign cor[AXIS_YAW]   = req_bus.corrected_yaw;

   cap_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd)
   );

   cap_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .des_in    (des),
      .sen_in    (sen),
      .cor_in    (cor),
      .drive_out (drive)
   );

   assign rsp_bus.roll_drive  = drive[AXIS_ROLL];
   assign rsp_bus.pitch_drive = drive[AXIS_PITCH];
   assign rsp_bus.yaw_drive   = drive[AXIS_YAW];

endmodule

// ===== hdl/cap_ctrl.sv =====
module cap_ctrl import cap_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output cap_cmd_type cmd
);

   cap_state_type state_ff, state_in;
   axis_type      axis_ff, axis_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          emit_ok;

   // output slot is free when empty or being drained this cycle
   assign emit_ok = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_ERR;
               axis_in  = AXIS_ROLL;
            end
         end
         ST_ERR:   state_in = ST_MDT;
         ST_MDT:   state_in = ST_INTEG;
         ST_INTEG: state_in = ST_CMD1;
         ST_CMD1:  state_in = ST_CMD2;
         ST_CMD2:  state_in = ST_RLO;
         ST_RLO:   state_in = ST_RHI;
         ST_RHI:   state_in = ST_OUT;
         ST_OUT: begin
            if (axis_ff == AXIS_YAW) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_ERR;
               axis_in  = axis_type'(axis_ff + 1'b1);
            end
         end
         ST_EMIT: begin
            if (emit_ok) state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd.op       = OP_NONE;
      cmd.axis     = axis_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = OP_LOAD;
         end
         ST_ERR:   cmd.op = OP_ERR;
         ST_MDT:   cmd.op = OP_MDT;
         ST_INTEG: cmd.op = OP_INTEG;
         ST_CMD1:  cmd.op = OP_CMD1;
         ST_CMD2:  cmd.op = OP_CMD2;
         ST_RLO:   cmd.op = OP_RLO;
         ST_RHI:   cmd.op = OP_RHI;
         ST_OUT:   cmd.op = OP_OUT;
         ST_EMIT: begin
            if (emit_ok) begin
               cmd.op       = OP_EMIT;
               rsp_valid_in = 1'b1;
            end
         end
         default:  cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= AXIS_ROLL;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_axis_range: assert property (@(posedge clock) disable iff (reset)
      axis_ff <= AXIS_YAW)
      else $error("axis counter out of range");

   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_ERR && axis_ff == AXIS_ROLL)
      else $error("accepted beat did not start at roll");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_EMIT |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten while pending");

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_EMIT |=> rsp_valid_ff)
      else $error("emitted result not presented");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req_ready)
      else $error("input taken mid-computation");

endmodule

// ===== hdl/cap_dp.sv =====
module cap_dp import cap_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cap_cmd_type           cmd,
   input  logic                  csr_wr_en,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  angle_type             des_in [NUM_AXES],
   input  angle_type             sen_in [NUM_AXES],
   input  angle_type             cor_in [NUM_AXES],
   output angle_type             drive_out [NUM_AXES]
);

   localparam logic signed [ACC_W-1:0] SAT_HI =
      {{(ACC_W-INTEG_W+1){1'b0}}, {(INTEG_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SAT_LO =
      {{(ACC_W-INTEG_W+1){1'b1}}, {(INTEG_W-1){1'b0}}};

   logic [GAINS_W-1:0]          gains_ff [NUM_AXES];
   logic [LIMITS_W-1:0]         limits_ff [NUM_AXES];
   logic [DT_W-1:0]             dt_ff;
   logic signed [INTEG_W-1:0]   integ_ff [NUM_AXES];

   angle_type                   des_ff [NUM_AXES];
   angle_type                   sen_ff [NUM_AXES];
   angle_type                   cor_ff [NUM_AXES];
   angle_type                   drive_ff [NUM_AXES];
   angle_type                   rsp_ff [NUM_AXES];
   logic signed [ERR_W-1:0]     err_ff;
   logic signed [PROD_W-1:0]    prod_ff;
   logic signed [SUM_W-1:0]     sum_ff;
   logic signed [DRV_W-1:0]     drv_ff;

   logic [GAINS_W-1:0]          gains;
   logic [LIMITS_W-1:0]         limits;
   logic [GAIN_W-1:0]           kp, ki, kr;
   angle_type                   elim, ilim, omax, omin;

   logic signed [ERR_W-1:0]     e_raw, e_wrap, e_hi, e_lo, err_in;
   logic signed [ACC_W-1:0]     acc_sum, acc_hi, acc_lo, acc_clamp, acc_sat;
   logic signed [INTEG_W-1:0]   integ_in;
   logic signed [DIFF_W-1:0]    diff;
   logic signed [DRV_W-1:0]     drv_sum;
   logic signed [QUO_W-1:0]     quo, q_hi, q_lo, quo_clamp;
   angle_type                   drive_in;
   logic signed [MUL_A_W-1:0]   mul_a;
   logic signed [MUL_B_W-1:0]   mul_b;
   logic signed [PROD_W-1:0]    product;

   assign gains  = gains_ff[cmd.axis];
   assign limits = limits_ff[cmd.axis];
   assign kp     = gains[GAIN_W-1:0];
   assign ki     = gains[2*GAIN_W-1:GAIN_W];
   assign kr     = gains[3*GAIN_W-1:2*GAIN_W];
   assign elim   = $signed(limits[ANGLE_W-1:0]);
   assign ilim   = $signed(limits[2*ANGLE_W-1:ANGLE_W]);
   assign omax   = $signed(limits[3*ANGLE_W-1:2*ANGLE_W]);
   assign omin   = $signed(limits[4*ANGLE_W-1:3*ANGLE_W]);

   // angle error: difference, yaw wrap, symmetric clamp
   always_comb begin
      e_raw  = ERR_W'(des_ff[cmd.axis]) - ERR_W'(sen_ff[cmd.axis]);
      e_wrap = e_raw;
      if (cmd.axis == AXIS_YAW) begin
         if (e_raw > ERR_W'(HALF_TURN))       e_wrap = e_raw - ERR_W'(FULL_TURN);
         else if (e_raw < ERR_W'(-HALF_TURN)) e_wrap = e_raw + ERR_W'(FULL_TURN);
      end
      e_hi = ERR_W'(elim);
      e_lo = -e_hi;
      if (e_wrap >= e_hi)      err_in = e_hi;
      else if (e_wrap <= e_lo) err_in = e_lo;
      else                     err_in = e_wrap;
   end

   // integrator update: prod_ff holds err*dt here
   always_comb begin
      acc_sum = ACC_W'(integ_ff[cmd.axis]) + ACC_W'(prod_ff);
      acc_hi  = ACC_W'(ilim) <<< FRAC_W;
      acc_lo  = -acc_hi;
      if (acc_sum >= acc_hi)      acc_clamp = acc_hi;
      else if (acc_sum <= acc_lo) acc_clamp = acc_lo;
      else                        acc_clamp = acc_sum;
      if (acc_clamp > SAT_HI)      acc_sat = SAT_HI;
      else if (acc_clamp < SAT_LO) acc_sat = SAT_LO;
      else                         acc_sat = acc_clamp;
      integ_in = INTEG_W'(acc_sat);
   end

   assign diff = DIFF_W'(sum_ff >>> DIFF_SHIFT);

   // final drive: low partial product in drv_ff, high one in prod_ff
   always_comb begin
      drv_sum = drv_ff + (DRV_W'(prod_ff) <<< DIFF_LO_W);
      quo     = QUO_W'(drv_sum >>> CMD_SHIFT);
      q_hi    = QUO_W'(omax);
      q_lo    = QUO_W'(omin);
      if (quo >= q_hi)      quo_clamp = q_hi;
      else if (quo <= q_lo) quo_clamp = q_lo;
      else                  quo_clamp = quo;
      drive_in = ANGLE_W'(quo_clamp);
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_MDT: begin
            mul_a = MUL_A_W'(err_ff);
            mul_b = {1'b0, dt_ff};
         end
         OP_INTEG: begin
            mul_a = MUL_A_W'(err_ff);
            mul_b = {1'b0, kp};
         end
         OP_CMD1: begin
            mul_a = MUL_A_W'(integ_ff[cmd.axis]);
            mul_b = {1'b0, ki};
         end
         OP_RLO: begin
            mul_a = MUL_A_W'(diff[DIFF_LO_W-1:0]);
            mul_b = {1'b0, kr};
         end
         OP_RHI: begin
            mul_a = MUL_A_W'($signed(diff[DIFF_W-1:DIFF_LO_W]));
            mul_b = {1'b0, kr};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign product = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            gains_ff[i]  <= '0;
            limits_ff[i] <= '0;
            integ_ff[i]  <= '0;
         end
         dt_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_GAINS_ROLL:   gains_ff[AXIS_ROLL]   <= csr_wdata[GAINS_W-1:0];
               CSR_GAINS_PITCH:  gains_ff[AXIS_PITCH]  <= csr_wdata[GAINS_W-1:0];
               CSR_GAINS_YAW:    gains_ff[AXIS_YAW]    <= csr_wdata[GAINS_W-1:0];
               CSR_LIMITS_ROLL:  limits_ff[AXIS_ROLL]  <= csr_wdata[LIMITS_W-1:0];
               CSR_LIMITS_PITCH: limits_ff[AXIS_PITCH] <= csr_wdata[LIMITS_W-1:0];
               CSR_LIMITS_YAW:   limits_ff[AXIS_YAW]   <= csr_wdata[LIMITS_W-1:0];
               CSR_TIME_STEP:    dt_ff                 <= csr_wdata[DT_W-1:0];
               default: ;
            endcase
         end
         if (cmd.op == OP_INTEG) integ_ff[cmd.axis] <= integ_in;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            for (int i = 0; i < NUM_AXES; i++) begin
               des_ff[i] <= des_in[i];
               sen_ff[i] <= sen_in[i];
               cor_ff[i] <= cor_in[i];
            end
         end
         OP_ERR:   err_ff <= err_in;
         OP_MDT:   prod_ff <= product;
         OP_INTEG: prod_ff <= product;
         OP_CMD1: begin
            sum_ff  <= (SUM_W'(prod_ff) <<< FRAC_W) - (SUM_W'(cor_ff[cmd.axis]) <<< CMD_SHIFT);
            prod_ff <= product;
         end
         OP_CMD2:  sum_ff <= sum_ff + SUM_W'(prod_ff);
         OP_RLO:   prod_ff <= product;
         OP_RHI: begin
            drv_ff  <= DRV_W'(prod_ff);
            prod_ff <= product;
         end
         OP_OUT:   drive_ff[cmd.axis] <= drive_in;
         OP_EMIT: begin
            for (int i = 0; i < NUM_AXES; i++) rsp_ff[i] <= drive_ff[i];
         end
         default: ;
      endcase
   end

   assign drive_out = rsp_ff;

endmodule

// ===== tb/tb.sv =====
module tb import cap_pkg::*; ();

   localparam csr_index_type CSR_UNUSED = 3'd7;

   typedef struct {
      angle_type desired[3];
      angle_type sensed[3];
      angle_type corrected[3];
   } tick_t;

   typedef struct {
      angle_type drive[3];
   } drives_t;

   typedef struct {
      logic [63:0] gains[3];
      logic [63:0] limits[3];
      logic [63:0] dt;
   } setting_t;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   cap_req_if req_bus ();
   cap_rsp_if rsp_bus ();

   cascaded_attitude_pi_controller u_top (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor copy of the registers and integrators
   logic [GAINS_W-1:0]  gain_reg  [3] = '{default: '0};
   logic [LIMITS_W-1:0] limit_reg [3] = '{default: '0};
   logic [DT_W-1:0]     dt_reg = '0;
   int                  integ_q16 [3] = '{default: 0};

   tick_t       pending_ticks[$];
   drives_t     expected_drives[$];
   int          ticks_offered = 0;
   int          ticks_accepted = 0;
   int          drives_checked = 0;
   int          settings_applied = 0;
   int          failures = 0;
   int unsigned req_idle_pct = 20;
   int unsigned rsp_stall_pct = 86;
   string       axis_name [3] = '{"roll", "pitch", "yaw"};

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic longint clamp_hl(longint v, longint hi, longint lo);
      if (v >= hi) return hi;
      if (v <= lo) return lo;
      return v;
   endfunction

   // one axis of the cascade; advances that axis' integrator
   function automatic angle_type axis_drive(axis_type ax, angle_type des, angle_type sen,
                                            angle_type cor);
      longint kp, ki, kr, elim, ilim, omax, omin, err, acc, cmd, diff;
      kp   = longint'(gain_reg[ax][15:0]);
      ki   = longint'(gain_reg[ax][31:16]);
      kr   = longint'(gain_reg[ax][47:32]);
      elim = longint'($signed(limit_reg[ax][15:0]));
      ilim = longint'($signed(limit_reg[ax][31:16]));
      omax = longint'($signed(limit_reg[ax][47:32]));
      omin = longint'($signed(limit_reg[ax][63:48]));
      err  = longint'(des) - longint'(sen);
      if (ax == AXIS_YAW) begin
         if (err > HALF_TURN) err = err - FULL_TURN;
         else if (err < -HALF_TURN) err = err + FULL_TURN;
      end
      err = clamp_hl(err, elim, -elim);
      acc = longint'(integ_q16[ax]) + err * longint'(dt_reg);
      acc = clamp_hl(acc, ilim * 65536, -ilim * 65536);
      if (acc > 64'sd2147483647) acc = 64'sd2147483647;
      if (acc < -64'sd2147483648) acc = -64'sd2147483648;
      integ_q16[ax] = int'(acc);
      cmd  = kp * err * 65536 + ki * acc;
      diff = (cmd - longint'(cor) * 16777216) >>> 8;
      return angle_type'(clamp_hl((kr * diff) >>> 24, omax, omin));
   endfunction

   task automatic report_failure(string what);
      failures++;
      if (failures <= 10) $display("%s", what);
   endtask

   task automatic write_csr(csr_index_type idx, logic [63:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_GAINS_ROLL:   gain_reg[AXIS_ROLL]   = value[GAINS_W-1:0];
         CSR_GAINS_PITCH:  gain_reg[AXIS_PITCH]  = value[GAINS_W-1:0];
         CSR_GAINS_YAW:    gain_reg[AXIS_YAW]    = value[GAINS_W-1:0];
         CSR_LIMITS_ROLL:  limit_reg[AXIS_ROLL]  = value;
         CSR_LIMITS_PITCH: limit_reg[AXIS_PITCH] = value;
         CSR_LIMITS_YAW:   limit_reg[AXIS_YAW]   = value;
         CSR_TIME_STEP:    dt_reg = value[DT_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic apply_setting(setting_t s);
      write_csr(CSR_GAINS_ROLL,   s.gains[AXIS_ROLL]);
      write_csr(CSR_GAINS_PITCH,  s.gains[AXIS_PITCH]);
      write_csr(CSR_GAINS_YAW,    s.gains[AXIS_YAW]);
      write_csr(CSR_LIMITS_ROLL,  s.limits[AXIS_ROLL]);
      write_csr(CSR_LIMITS_PITCH, s.limits[AXIS_PITCH]);
      write_csr(CSR_LIMITS_YAW,   s.limits[AXIS_YAW]);
      write_csr(CSR_TIME_STEP,    s.dt);
      settings_applied++;
   endtask

   function automatic setting_t uniform_setting(logic [15:0] kp, logic [15:0] ki,
                                                logic [15:0] kr, logic [15:0] elim,
                                                logic [15:0] ilim, logic [15:0] omax,
                                                logic [15:0] omin, logic [15:0] dt);
      setting_t s;
      for (int a = 0; a < NUM_AXES; a++) begin
         s.gains[a]  = {16'hFFFF, kr, ki, kp};
         s.limits[a] = {omin, omax, ilim, elim};
      end
      s.dt = {48'hFFFF_FFFF_FFFF, dt};
      return s;
   endfunction

   function automatic logic [15:0] rand_gain();
      case ($urandom_range(9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'($urandom);
         default: return 16'($urandom_range(1023));
      endcase
   endfunction

   function automatic setting_t random_setting();
      setting_t    s;
      logic [15:0] elim, ilim, omax, omin, dt;
      for (int a = 0; a < NUM_AXES; a++) begin
         s.gains[a] = {16'($urandom), rand_gain(), rand_gain(), rand_gain()};
         case ($urandom_range(9))
            0: elim = 16'h0000;
            1: elim = 16'h7FFF;
            2: elim = 16'($urandom);
            default: elim = 16'($urandom_range(720, 1));
         endcase
         case ($urandom_range(9))
            0: ilim = 16'h0000;
            1: ilim = 16'h7FFF;
            2: ilim = 16'($urandom);
            3: ilim = 16'h8000;
            default: ilim = 16'($urandom_range(3000, 1));
         endcase
         case ($urandom_range(9))
            0: omax = 16'h7FFF;
            1: omax = 16'($urandom);
            default: omax = 16'($urandom_range(20000));
         endcase
         case ($urandom_range(9))
            0: omin = 16'h8000;
            1: omin = 16'($urandom);
            default: omin = 16'(-int'($urandom_range(20000)));
         endcase
         s.limits[a] = {omin, omax, ilim, elim};
      end
      case ($urandom_range(9))
         0: dt = 16'h0000;
         1: dt = 16'hFFFF;
         2, 3: dt = 16'($urandom);
         default: dt = 16'($urandom_range(4096, 1));
      endcase
      s.dt = {$urandom, 16'($urandom), dt};
      return s;
   endfunction

   // mostly angles near the wrap region, some wide, some anywhere
   function automatic angle_type rand_angle();
      case ($urandom_range(3))
         0, 1: return angle_type'(int'($urandom_range(800)) - 400);
         2: return angle_type'(int'($urandom_range(8000)) - 4000);
         default: return angle_type'($urandom);
      endcase
   endfunction

   task automatic queue_uniform(angle_type d, angle_type s, angle_type c);
      tick_t t;
      for (int a = 0; a < NUM_AXES; a++) begin
         t.desired[a]   = d;
         t.sensed[a]    = s;
         t.corrected[a] = c;
      end
      pending_ticks.push_back(t);
   endtask

   task automatic drain();
      while (pending_ticks.size() != 0 || ticks_accepted != ticks_offered ||
             expected_drives.size() != 0)
         @(negedge clock);
   endtask

   // request driver and response back-pressure
   always @(negedge clock) begin : req_driver
      tick_t t;
      rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!(req_bus.valid && ticks_accepted != ticks_offered)) begin
         if (pending_ticks.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
            t = pending_ticks.pop_front();
            req_bus.desired_roll    <= t.desired[AXIS_ROLL];
            req_bus.desired_pitch   <= t.desired[AXIS_PITCH];
            req_bus.desired_yaw     <= t.desired[AXIS_YAW];
            req_bus.sensed_roll     <= t.sensed[AXIS_ROLL];
            req_bus.sensed_pitch    <= t.sensed[AXIS_PITCH];
            req_bus.sensed_yaw      <= t.sensed[AXIS_YAW];
            req_bus.corrected_roll  <= t.corrected[AXIS_ROLL];
            req_bus.corrected_pitch <= t.corrected[AXIS_PITCH];
            req_bus.corrected_yaw   <= t.corrected[AXIS_YAW];
            req_bus.valid <= 1'b1;
            ticks_offered++;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : beat_monitor
      drives_t want, got;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            want.drive[AXIS_ROLL]  = axis_drive(AXIS_ROLL, req_bus.desired_roll,
                                                req_bus.sensed_roll, req_bus.corrected_roll);
            want.drive[AXIS_PITCH] = axis_drive(AXIS_PITCH, req_bus.desired_pitch,
                                                req_bus.sensed_pitch, req_bus.corrected_pitch);
            want.drive[AXIS_YAW]   = axis_drive(AXIS_YAW, req_bus.desired_yaw,
                                                req_bus.sensed_yaw, req_bus.corrected_yaw);
            expected_drives.push_back(want);
            ticks_accepted++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.drive[AXIS_ROLL]  = rsp_bus.roll_drive;
            got.drive[AXIS_PITCH] = rsp_bus.pitch_drive;
            got.drive[AXIS_YAW]   = rsp_bus.yaw_drive;
            if (expected_drives.size() == 0) begin
               report_failure($sformatf("drive beat with no tick outstanding: %0d %0d %0d",
                                        got.drive[AXIS_ROLL], got.drive[AXIS_PITCH],
                                        got.drive[AXIS_YAW]));
            end else begin
               want = expected_drives.pop_front();
               for (int a = 0; a < NUM_AXES; a++)
                  if (got.drive[a] !== want.drive[a])
                     report_failure($sformatf("beat %0d %s_drive: expected %0d, got %0d",
                                              drives_checked, axis_name[a],
                                              want.drive[a], got.drive[a]));
            end
            drives_checked++;
         end
      end
   end

   initial begin : stimulus
      tick_t t;
      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_index     = CSR_GAINS_ROLL;
      csr_wdata     = '0;
      rsp_bus.ready = 1'b0;
      req_bus.valid = 1'b0;
      req_bus.desired_roll    = '0;
      req_bus.desired_pitch   = '0;
      req_bus.desired_yaw     = '0;
      req_bus.sensed_roll     = '0;
      req_bus.sensed_pitch    = '0;
      req_bus.sensed_yaw      = '0;
      req_bus.corrected_roll  = '0;
      req_bus.corrected_pitch = '0;
      req_bus.corrected_yaw   = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // registers still at their reset values
      queue_uniform(16'sd100, 16'sd0, 16'sd5);
      queue_uniform(16'sh7FFF, -16'sh8000, -16'sh8000);
      drain();

      // unity-ish gains, widest limits; yaw wrap edges and field extremes
      apply_setting(uniform_setting(16'h0100, 16'h0080, 16'h0100, 16'h7FFF, 16'h7FFF,
                                    16'h7FFF, 16'h8000, 16'h1000));
      queue_uniform(16'sd0, 16'sd0, 16'sd0);
      queue_uniform(16'sd181, 16'sd0, 16'sd0);
      queue_uniform(16'sd180, 16'sd0, 16'sd0);
      queue_uniform(-16'sd180, 16'sd0, 16'sd0);
      queue_uniform(-16'sd181, 16'sd0, 16'sd0);
      queue_uniform(16'sd600, -16'sd300, 16'sd0);
      queue_uniform(-16'sd600, 16'sd300, 16'sd0);
      queue_uniform(16'sh7FFF, -16'sh8000, 16'sd0);
      queue_uniform(-16'sh8000, 16'sh7FFF, 16'sd0);
      queue_uniform(16'sd0, 16'sd0, 16'sh7FFF);
      queue_uniform(16'sd0, 16'sd0, -16'sh8000);
      queue_uniform(16'sh7FFF, 16'sh7FFF, -16'sh8000);
      drain();

      // largest gains
      apply_setting(uniform_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF,
                                    16'h7FFF, 16'h8000, 16'hFFFF));
      queue_uniform(16'sd10, 16'sd0, 16'sd0);
      queue_uniform(-16'sd10, 16'sd0, 16'sd0);
      queue_uniform(16'sd0, 16'sd0, 16'sd100);
      queue_uniform(16'sh7FFF, -16'sh8000, 16'sh7FFF);
      drain();

      // inverted limits: integrator swings into 32-bit saturation
      apply_setting(uniform_setting(16'h0100, 16'h0100, 16'h0100, 16'h8000, 16'h8000,
                                    16'h8000, 16'h7FFF, 16'hFFFF));
      queue_uniform(16'sd0, 16'sd0, 16'sd0);
      queue_uniform(-16'sd300, 16'sd0, 16'sd0);
      queue_uniform(16'sd300, 16'sd0, 16'sd0);
      queue_uniform(-16'sh8000, 16'sh7FFF, 16'sd0);
      drain();

      // every register bit set
      apply_setting(uniform_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                    16'hFFFF, 16'hFFFF, 16'hFFFF));
      write_csr(CSR_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
      queue_uniform(16'sd1, -16'sd1, 16'sd0);
      queue_uniform(-16'sd1, 16'sd1, 16'sh7FFF);
      queue_uniform(16'sh7FFF, -16'sh8000, -16'sh8000);
      drain();

      for (int r = 0; r < 14; r++) begin
         if (r == 5) begin
            req_idle_pct  = 86;
            rsp_stall_pct = 20;
         end else if (r == 10) begin
            req_idle_pct  = 0;
            rsp_stall_pct = 0;
         end
         apply_setting(random_setting());
         if (r % 4 == 0) write_csr(CSR_UNUSED, {$urandom, $urandom});
         for (int n = 0; n < 100; n++) begin
            for (int a = 0; a < NUM_AXES; a++) begin
               t.desired[a]   = rand_angle();
               t.sensed[a]    = rand_angle();
               t.corrected[a] = rand_angle();
            end
            pending_ticks.push_back(t);
         end
         drain();
      end

      // let any stray beat show up
      repeat (60) @(negedge clock);
      if (expected_drives.size() != 0)
         report_failure($sformatf("%0d drive beats never arrived", expected_drives.size()));
      $display("%0d control ticks under %0d register settings, %0d drive beats checked",
               ticks_accepted, settings_applied, drives_checked);
      $display("%0d failures", failures);
      if (failures == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

   initial begin : watchdog
      #(8 * 400000);
      $display("tb NOT OK");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/cap_pkg.sv
hdl/cap_if.sv
hdl/cap_ctrl.sv
hdl/cap_dp.sv
hdl/cascaded_attitude_pi_controller.sv
tb/tb.sv
